// ===== src/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants for the MAC learning table: the token that
// walks the row of table cells, aging constants and reset values.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 64;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned PORT_W  = 4;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 7;

    localparam logic [TIME_W-1:0] AGE_STEP        = 16'd5;
    localparam logic [TIME_W-1:0] AGE_TIMEOUT_RST = 16'd300;
    localparam logic [MAC_W-1:0]  MAC_BCAST       = 48'hFFFF_FFFF_FFFF;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Running result of one item as it passes from cell to cell
    typedef struct packed {
        logic               active;
        logic               src_match;
        logic               dst_found;
        logic [PORT_W-1:0]  dport;
        logic               moved;
        logic               free_found;
        logic [COUNT_W-1:0] expired;
    } t_token;

endpackage

// ===== src/mlt_cell.sv =====
// ----------------------------------------------------------------------------
// mlt_cell
// One table entry. Checks the passing token against its own entry, updates
// the entry and registers the token before handing it on to the next cell.
// ----------------------------------------------------------------------------
module mlt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_mode,
    input  logic [mlt_pkg::PORT_W-1:0] i_port,
    input  logic [mlt_pkg::MAC_W-1:0]  i_src,
    input  logic [mlt_pkg::MAC_W-1:0]  i_dst,
    input  logic [mlt_pkg::TIME_W-1:0] i_timeout,
    input  logic                      i_learn,
    input  mlt_pkg::t_token           i_tok,
    output mlt_pkg::t_token           o_tok
);
    import mlt_pkg::*;

    logic              r_valid, n_valid;
    logic              r_cand, n_cand;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic [PORT_W-1:0] r_port, n_port;
    logic [TIME_W-1:0] r_time, n_time;
    t_token            r_tok, n_tok;
    logic              src_hit, dst_hit;

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_cand  = r_cand;
        n_mac   = r_mac;
        n_port  = r_port;
        n_time  = r_time;
        src_hit = 1'b0;
        dst_hit = 1'b0;

        // learn into this entry if it was picked as the free slot
        if (i_learn && r_cand) begin
            n_valid = 1'b1;
            n_cand  = 1'b0;
            n_mac   = i_src;
            n_port  = i_port;
            n_time  = i_timeout;
        end

        if (i_tok.active) begin
            n_cand = 1'b0;
            if (i_mode == MODE_TICK) begin
                if (r_valid) begin
                    if (r_time <= AGE_STEP) begin
                        n_valid     = 1'b0;
                        n_tok.expired = i_tok.expired + 7'd1;
                    end else begin
                        n_time = r_time - AGE_STEP;
                    end
                end
            end else if (!r_valid) begin
                if (!i_tok.free_found) begin
                    n_tok.free_found = 1'b1;
                    n_cand           = 1'b1;
                end
            end else begin
                src_hit = !i_tok.src_match && (r_mac == i_src);
                dst_hit = !i_tok.dst_found && (r_mac == i_dst);
                if (src_hit) begin
                    n_tok.src_match = 1'b1;
                    n_port          = i_port;
                    n_time          = i_timeout;
                    if (r_port != i_port) begin
                        n_tok.moved = 1'b1;
                    end
                end
                if (dst_hit) begin
                    n_tok.dst_found = 1'b1;
                    n_tok.dport     = src_hit ? i_port : r_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cand  <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cand  <= n_cand;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac  <= n_mac;
        r_port <= n_port;
        r_time <= n_time;
    end

    assign o_tok = r_tok;

endmodule

// ===== src/mac_learning_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging
// Switch address table with source learning, destination lookup and aging.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ------------------------------------
//   in        input      i_valid / o_ready    i_mode, i_ingress_port, i_source_mac,
//                                             i_dest_mac
//   out       output     o_valid / i_ready    o_dest_known, o_dest_port,
//                                             o_dest_broadcast, o_source_learned,
//                                             o_source_moved, o_table_full,
//                                             o_expired_count
//   cfg       input      i_cfg_wr_en          i_cfg_wr_data (age_timeout)
//
// After acceptance a token walks the row of cells one entry per cycle, then the
// result is registered. One item is in the table at a time; o_ready is high
// only in idle, so the next item is not taken until the previous walk is done
// and its result has gone into the output register or the holding register.
// A result that cannot leave because the output is stalled waits in a holding
// register, and o_ready returns once it moves into the output register.
// Reset clears every entry's valid bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging #(
    parameter int unsigned TABLE_ENTRIES = mlt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item in
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [mlt_pkg::PORT_W-1:0]  i_ingress_port,
    input  logic [mlt_pkg::MAC_W-1:0]   i_source_mac,
    input  logic [mlt_pkg::MAC_W-1:0]   i_dest_mac,
    // result out
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_dest_known,
    output logic [mlt_pkg::PORT_W-1:0]  o_dest_port,
    output logic                        o_dest_broadcast,
    output logic                        o_source_learned,
    output logic                        o_source_moved,
    output logic                        o_table_full,
    output logic [mlt_pkg::COUNT_W-1:0] o_expired_count,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [mlt_pkg::TIME_W-1:0]  i_cfg_wr_data
);
    import mlt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    // packed result item as it leaves the table
    typedef struct packed {
        logic               dest_known;
        logic [PORT_W-1:0]  lookup_port;
        logic               dest_broadcast;
        logic               source_learned;
        logic               source_moved;
        logic               table_full;
        logic [COUNT_W-1:0] expired_count;
    } t_result;

    t_state            r_state, n_state;
    logic [TIME_W-1:0] r_age_timeout;

    // held item, broadcast to every cell during the walk
    logic              r_mode;
    logic [PORT_W-1:0] r_port;
    logic [MAC_W-1:0]  r_src;
    logic [MAC_W-1:0]  r_dst;

    logic              r_start;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;
    t_result           r_pend, n_pend;

    t_token            w_tok [TABLE_ENTRIES+1];
    t_token            fin;
    t_result           res;
    logic              in_fire;
    logic              out_free;
    logic              learn;

    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign fin      = w_tok[TABLE_ENTRIES];

    // fresh token enters the first cell the cycle after acceptance
    always_comb begin
        w_tok[0]        = '0;
        w_tok[0].active = r_start;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            mlt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_mode    (r_mode),
                .i_port    (r_port),
                .i_src     (r_src),
                .i_dst     (r_dst),
                .i_timeout (r_age_timeout),
                .i_learn   (learn),
                .i_tok     (w_tok[g]),
                .o_tok     (w_tok[g+1])
            );
        end
    endgenerate

    // learn the source into the chosen free entry when the walk finds no match
    assign learn = fin.active && (r_mode == MODE_FRAME) && !fin.src_match && fin.free_found;

    always_comb begin
        res = '0;
        if (r_mode == MODE_TICK) begin
            res.expired_count = fin.expired;
        end else begin
            res.dest_known     = fin.dst_found;
            res.lookup_port    = fin.dst_found ? fin.dport : '0;
            res.dest_broadcast = (r_dst == MAC_BCAST);
            res.source_learned = !fin.src_match && fin.free_found;
            res.source_moved   = fin.moved;
            res.table_full     = !fin.src_match && !fin.free_found;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pend      = r_pend;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (fin.active) begin
                    if (out_free) begin
                        n_out       = res;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_pend  = res;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_start       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_age_timeout <= AGE_TIMEOUT_RST;
        end else begin
            r_state     <= n_state;
            r_start     <= in_fire;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_age_timeout <= i_cfg_wr_data;
            end
        end
    end

    // hold the item and result payloads
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_mode;
            r_port <= i_ingress_port;
            r_src  <= i_source_mac;
            r_dst  <= i_dest_mac;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_dest_known     = r_out.dest_known;
    assign o_dest_port      = r_out.lookup_port;
    assign o_dest_broadcast = r_out.dest_broadcast;
    assign o_source_learned = r_out.source_learned;
    assign o_source_moved   = r_out.source_moved;
    assign o_table_full     = r_out.table_full;
    assign o_expired_count  = r_out.expired_count;

endmodule

// ===== src/mlt_checker.sv =====
// ----------------------------------------------------------------------------
// mlt_checker
// Port-level checks on the MAC learning table, bound to the top level.
// ----------------------------------------------------------------------------
module mlt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_dest_known,
    input logic [mlt_pkg::PORT_W-1:0]  o_dest_port,
    input logic                        o_dest_broadcast,
    input logic                        o_source_learned,
    input logic                        o_source_moved,
    input logic                        o_table_full,
    input logic [mlt_pkg::COUNT_W-1:0] o_expired_count
);

    // a result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before it was taken");

    // one item at a time: the table is busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item accepted during a table walk");

    // learned, moved and full exclude each other
    a_src_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_source_learned && o_table_full)
                 && !(o_source_learned && o_source_moved)
                 && !(o_source_moved && o_table_full))
        else $error("conflicting source flags");

    // an unknown destination reports port zero
    a_unknown_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dest_known |-> o_dest_port == '0)
        else $error("port reported for unknown destination");

    // an aging result carries no frame flags
    a_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_expired_count != '0) |-> !o_dest_known && !o_dest_broadcast
            && !o_source_learned && !o_source_moved && !o_table_full)
        else $error("frame flags set in an aging result");

endmodule

bind mac_learning_table_with_aging mlt_checker u_mlt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_dest_known     (o_dest_known),
    .o_dest_port      (o_dest_port),
    .o_dest_broadcast (o_dest_broadcast),
    .o_source_learned (o_source_learned),
    .o_source_moved   (o_source_moved),
    .o_table_full     (o_table_full),
    .o_expired_count  (o_expired_count)
);

// ===== bench/mac_learning_table_with_aging_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging_tb
// Self-checking bench for the MAC learning table. A short directed table
// covers empty-table ticks, all-zero and all-ones addresses, port moves,
// broadcast and expiry at the minimum timeout. Random traffic then runs in
// four phases with different age timeouts and address pools, ending with
// the table filling up. Every accepted item is run through a bench-side
// model of the table, and each result is compared field by field.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_tb;

    import mlt_pkg::*;

    localparam int unsigned N_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int unsigned ITEM_LATENCY = N_ENTRIES + 2;
    localparam int unsigned IDLE_PCT     = 23;
    localparam int unsigned POOL_SIZE    = 128;
    localparam int unsigned DIR_ROWS     = 16;
    localparam realtime     CLK_HALF     = 4.0;
    localparam realtime     WATCHDOG_NS  = 2_000_000.0;

    localparam logic [MAC_W-1:0] MAC_ZERO = 48'h0000_0000_0000;
    localparam logic [MAC_W-1:0] MAC_ONE  = 48'h0000_0000_0001;
    localparam logic [MAC_W-1:0] MAC_TOP  = 48'h8000_0000_0000;
    localparam logic [MAC_W-1:0] MAC_ALT1 = 48'hAAAA_AAAA_AAAA;
    localparam logic [MAC_W-1:0] MAC_ALT0 = 48'h5555_5555_5555;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One result of the table, in port order
    typedef struct packed {
        logic               known;
        logic [PORT_W-1:0]  port;
        logic               bcast;
        logic               learned;
        logic               moved;
        logic               full;
        logic [COUNT_W-1:0] expired;
    } t_lookup_result;

    // One line of the directed table: either a timeout write or an item
    typedef struct {
        t_row_kind         kind;
        logic [TIME_W-1:0] timeout;
        logic              mode;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  src;
        logic [MAC_W-1:0]  dst;
        bit                typed;
        t_lookup_result    want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_mode;
    logic [PORT_W-1:0]    i_ingress_port;
    logic [MAC_W-1:0]     i_source_mac;
    logic [MAC_W-1:0]     i_dest_mac;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_dest_known;
    logic [PORT_W-1:0]    o_dest_port;
    logic                 o_dest_broadcast;
    logic                 o_source_learned;
    logic                 o_source_moved;
    logic                 o_table_full;
    logic [COUNT_W-1:0]   o_expired_count;
    logic                 i_cfg_wr_en;
    logic [TIME_W-1:0]    i_cfg_wr_data;

    // Bench copy of the address table and its timeout register
    logic                 tbl_valid [N_ENTRIES];
    logic [MAC_W-1:0]     tbl_mac   [N_ENTRIES];
    logic [PORT_W-1:0]    tbl_port  [N_ENTRIES];
    logic [TIME_W-1:0]    tbl_age   [N_ENTRIES];
    logic [TIME_W-1:0]    age_limit;

    t_lookup_result       results_due[$];
    t_lookup_result       head;
    int unsigned          err_count = 0;
    bit                   calm = 1'b0;   // set to suppress idling on both sides

    mac_learning_table_with_aging #(
        .TABLE_ENTRIES   (N_ENTRIES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_ingress_port  (i_ingress_port),
        .i_source_mac    (i_source_mac),
        .i_dest_mac      (i_dest_mac),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_dest_known    (o_dest_known),
        .o_dest_port     (o_dest_port),
        .o_dest_broadcast(o_dest_broadcast),
        .o_source_learned(o_source_learned),
        .o_source_moved  (o_source_moved),
        .o_table_full    (o_table_full),
        .o_expired_count (o_expired_count),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #(CLK_HALF);
        i_clk = 1'b0;
        #(CLK_HALF);
    end

    // Age the table or learn and look up one frame; return what the block must report.
    // The destination scan runs in the same pass as the source scan, so it sees a
    // refreshed port but not a slot that this frame learns afterwards.
    function automatic t_lookup_result table_step(input logic mode,
                                                  input logic [PORT_W-1:0] port,
                                                  input logic [MAC_W-1:0] src,
                                                  input logic [MAC_W-1:0] dst);
        t_lookup_result r;
        bit             src_hit;
        bit             dst_hit;
        int             free_idx;
        r        = '0;
        src_hit  = 1'b0;
        dst_hit  = 1'b0;
        free_idx = -1;
        if (mode == MODE_TICK) begin
            // Drop every slot at or below one step; charge a step to the rest
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!tbl_valid[i]) continue;
                if (tbl_age[i] <= AGE_STEP) begin
                    tbl_valid[i] = 1'b0;
                    r.expired    = r.expired + 1'b1;
                end else begin
                    tbl_age[i] = tbl_age[i] - AGE_STEP;
                end
            end
        end else begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    if (free_idx < 0) free_idx = i;
                    continue;
                end
                if (!src_hit && tbl_mac[i] == src) begin
                    if (tbl_port[i] != port) begin
                        tbl_port[i] = port;
                        r.moved     = 1'b1;
                    end
                    tbl_age[i] = age_limit;
                    src_hit    = 1'b1;
                end
                if (!dst_hit && tbl_mac[i] == dst) begin
                    r.port  = tbl_port[i];
                    r.known = 1'b1;
                    dst_hit = 1'b1;
                end
            end
            // Learn into the lowest free slot, or flag a full table
            if (!src_hit) begin
                if (free_idx >= 0) begin
                    tbl_valid[free_idx] = 1'b1;
                    tbl_mac[free_idx]   = src;
                    tbl_port[free_idx]  = port;
                    tbl_age[free_idx]   = age_limit;
                    r.learned           = 1'b1;
                end else begin
                    r.full = 1'b1;
                end
            end
            r.bcast = (dst == MAC_BCAST);
        end
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    // Present one item at the falling edge, hold it until the table takes it, then
    // record its expected result. Return at a falling edge with valid still high,
    // so a back-to-back item never lowers and raises valid in one step.
    task automatic send_item(input logic mode, input logic [PORT_W-1:0] port,
                             input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                             input bit typed, input t_lookup_result want);
        t_lookup_result predicted;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_ingress_port <= port;
        i_source_mac   <= src;
        i_dest_mac     <= dst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // Always advance the model; typed rows replace only the expectation
        predicted = table_step(mode, port, src, dst);
        results_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Hold the sender until every expected result has come, then let the table settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_age_timeout(input logic [TIME_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        age_limit   = value;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Receiver: stall at random except during the calm stretch
    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t ns: result with no item pending, expired_count %0d",
                         $time, o_expired_count);
                err_count++;
            end else begin
                head = results_due.pop_front();
                check_field("o_dest_known",     32'(head.known),   32'(o_dest_known));
                check_field("o_dest_port",      32'(head.port),    32'(o_dest_port));
                check_field("o_dest_broadcast", 32'(head.bcast),   32'(o_dest_broadcast));
                check_field("o_source_learned", 32'(head.learned), 32'(o_source_learned));
                check_field("o_source_moved",   32'(head.moved),   32'(o_source_moved));
                check_field("o_table_full",     32'(head.full),    32'(o_table_full));
                check_field("o_expired_count",  32'(head.expired), 32'(o_expired_count));
            end
        end
    end

    initial begin
        t_stim_row         rows [DIR_ROWS];
        logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
        logic [PORT_W-1:0] home_port [POOL_SIZE];
        int unsigned       ph_timeout [4];
        int unsigned       ph_pool [4];
        int unsigned       ph_tick_pct [4];
        int unsigned       ph_items [4];
        int unsigned       idx;
        int unsigned       pick;
        logic              mode;
        logic [PORT_W-1:0] port;
        logic [MAC_W-1:0]  dst;

        // Drive every input to a known value before the first edge
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_mode         = MODE_FRAME;
        i_ingress_port = '0;
        i_source_mac   = '0;
        i_dest_mac     = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;

        age_limit = AGE_TIMEOUT_RST;
        for (int i = 0; i < N_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i]   = '0;
            tbl_port[i]  = '0;
            tbl_age[i]   = '0;
        end

        // Directed table. Typed expectations only where the answer is plain:
        // ticks that expire nothing, first learns, port moves seen by the lookup.
        rows[0]  = '{ROW_ITEM, '0, MODE_TICK, 4'hF, MAC_BCAST, MAC_BCAST, 1'b1, '0};
        rows[1]  = '{ROW_ITEM, '0, MODE_FRAME, 4'h0, MAC_ZERO, MAC_ZERO, 1'b1,
                     '{learned: 1'b1, default: '0}};
        rows[2]  = '{ROW_ITEM, '0, MODE_FRAME, 4'hF, MAC_BCAST, MAC_BCAST, 1'b1,
                     '{bcast: 1'b1, learned: 1'b1, default: '0}};
        // Known source moves to port 15; broadcast destination is also found
        rows[3]  = '{ROW_ITEM, '0, MODE_FRAME, 4'hF, MAC_ZERO, MAC_BCAST, 1'b1,
                     '{known: 1'b1, port: 4'hF, bcast: 1'b1, moved: 1'b1, default: '0}};
        // Lookup of its own source sees the refreshed port
        rows[4]  = '{ROW_ITEM, '0, MODE_FRAME, 4'h3, MAC_ZERO, MAC_ZERO, 1'b1,
                     '{known: 1'b1, port: 4'h3, moved: 1'b1, default: '0}};
        rows[5]  = '{ROW_ITEM, '0, MODE_FRAME, 4'h3, MAC_ZERO, MAC_ZERO, 1'b0, '0};
        rows[6]  = '{ROW_ITEM, '0, MODE_FRAME, 4'h9, MAC_ALT1, MAC_ALT0, 1'b0, '0};
        rows[7]  = '{ROW_ITEM, '0, MODE_FRAME, 4'h6, MAC_ALT0, MAC_ALT1, 1'b0, '0};
        rows[8]  = '{ROW_ITEM, '0, MODE_TICK, 4'h0, MAC_ZERO, MAC_ZERO, 1'b1, '0};
        // Minimum timeout: fresh slots die at the very next tick
        rows[9]  = '{ROW_CFG, 16'd5, MODE_FRAME, '0, '0, '0, 1'b0, '0};
        rows[10] = '{ROW_ITEM, '0, MODE_FRAME, 4'h7, MAC_ONE, MAC_TOP, 1'b0, '0};
        rows[11] = '{ROW_ITEM, '0, MODE_FRAME, 4'h8, MAC_TOP, MAC_ONE, 1'b0, '0};
        rows[12] = '{ROW_ITEM, '0, MODE_TICK, 4'h5, MAC_ALT1, MAC_ALT0, 1'b0, '0};
        rows[13] = '{ROW_ITEM, '0, MODE_FRAME, 4'h1, MAC_ALT1, MAC_ONE, 1'b0, '0};
        rows[14] = '{ROW_CFG, 16'hFFFF, MODE_FRAME, '0, '0, '0, 1'b0, '0};
        rows[15] = '{ROW_ITEM, '0, MODE_FRAME, 4'h2, MAC_ZERO, MAC_ALT0, 1'b0, '0};

        // Random phases: short life with a small pool, a mid timeout with no
        // idling for a stretch, the reset timeout, then the longest timeout
        // with a pool larger than the table so that it fills
        ph_timeout  = '{5, $urandom_range(60, 10), 32'(AGE_TIMEOUT_RST), 65535};
        ph_pool     = '{40, 80, 120, POOL_SIZE};
        ph_tick_pct = '{30, 20, 15, 5};
        ph_items    = '{130, 140, 140, 140};

        for (int i = 0; i < POOL_SIZE; i++) begin
            mac_pool[i]  = rand_mac();
            home_port[i] = 4'($urandom_range(15));
        end
        mac_pool[0] = MAC_BCAST;
        mac_pool[1] = MAC_ZERO;

        // Hold reset, then release at a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                drain_results();
                write_age_timeout(rows[k].timeout);
            end else begin
                send_item(rows[k].mode, rows[k].port, rows[k].src, rows[k].dst,
                          rows[k].typed, rows[k].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            write_age_timeout(ph_timeout[ph][TIME_W-1:0]);
            for (int n = 0; n < ph_items[ph]; n++) begin
                calm = (ph == 1 && n < 80);
                // Pause once mid-way through the third phase until the table has answered everything
                if (ph == 2 && n == 70) drain_results();
                mode = ($urandom_range(99) < ph_tick_pct[ph]) ? MODE_TICK : MODE_FRAME;
                idx  = $urandom_range(ph_pool[ph] - 1);
                // Most frames come in on the station's usual port
                port = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : home_port[idx];
                pick = $urandom_range(9);
                if (pick == 0) begin
                    dst = MAC_BCAST;
                end else if (pick == 1) begin
                    dst = rand_mac();
                end else begin
                    dst = mac_pool[$urandom_range(ph_pool[ph] - 1)];
                end
                send_item(mode, port, mac_pool[idx], dst, 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Drop valid, wait for the last results, then watch for stray ones
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (ITEM_LATENCY + 8) @(negedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #(WATCHDOG_NS);
        $display("%0t ns: timeout with %0d results outstanding", $time, results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
